### hw/rtl/dorq_pkg.sv
// Shared types and constants for the deadline-ordered ready queue.
package dorq_pkg;

  // Width of an absolute deadline in hundredths of a time unit.
  localparam int DEADLINE_WIDTH = 32;

  // Operation codes carried in the kind field.
  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_REMOVE = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;  // register the operation and the per-cell compare flags
    logic apply;    // update the cells and load the result register
  } dorq_cmd_t;

endpackage

### hw/rtl/dorq_if.sv
// Request and response channel interfaces for the deadline-ordered ready queue.
interface dorq_req_if
  import dorq_pkg::*;
#(
  parameter int ID_WIDTH = 10
) ();
  logic                      valid;
  logic                      ready;
  logic                      kind;
  logic [ID_WIDTH-1:0]       job_id;
  logic [DEADLINE_WIDTH-1:0] deadline;

  modport source (output valid, kind, job_id, deadline, input ready);
  modport sink (input valid, kind, job_id, deadline, output ready);
endinterface

interface dorq_rsp_if #(
  parameter int ID_WIDTH  = 10,
  parameter int OCC_WIDTH = 5
) ();
  logic                 valid;
  logic                 ready;
  logic                 head_valid;
  logic [ID_WIDTH-1:0]  head_job;
  logic [OCC_WIDTH-1:0] occupancy;
  logic                 dropped;

  modport source (output valid, head_valid, head_job, occupancy, dropped, input ready);
  modport sink (input valid, head_valid, head_job, occupancy, dropped, output ready);
endinterface

### hw/rtl/dorq_ctrl.sv
// Controller state machine for the deadline-ordered ready queue.
module dorq_ctrl
  import dorq_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  output dorq_cmd_t cmd
);

  localparam logic ST_IDLE  = 1'b0;
  localparam logic ST_APPLY = 1'b1;

  logic state;
  logic state_next;
  logic out_valid_next;

  // A new transaction is taken only while no operation is in flight.
  assign in_ready    = (state == ST_IDLE);
  assign cmd.capture = in_valid && in_ready;
  // The cells update once the result register is free or being emptied.
  assign cmd.apply   = (state == ST_APPLY) && (!out_valid || out_ready);

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (cmd.capture) begin
          state_next = ST_APPLY;
        end
      end
      ST_APPLY: begin
        if (cmd.apply) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Result register occupancy.
  always_comb begin
    priority if (cmd.apply) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  // Every applied operation leaves a result waiting on the output.
  a_apply_gives_result: assert property (@(posedge clk) disable iff (rst)
    cmd.apply |=> out_valid)
    else $error("applied operation did not present a result");

  // A captured transaction is always followed by the apply step.
  a_capture_to_apply: assert property (@(posedge clk) disable iff (rst)
    cmd.capture |=> (state == ST_APPLY))
    else $error("capture not followed by apply state");

  // A stalled result holds the operation back in the apply state.
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (state == ST_APPLY && out_valid && !out_ready) |=> (state == ST_APPLY && out_valid))
    else $error("operation left apply state while result was stalled");

endmodule

### hw/rtl/dorq_dp.sv
// Datapath of the deadline-ordered ready queue: a row of compare-and-shift cells.
module dorq_dp
  import dorq_pkg::*;
#(
  parameter int CAPACITY  = 16,
  parameter int ID_WIDTH  = 10,
  parameter int OCC_WIDTH = 5
) (
  input  logic                      clk,
  input  logic                      rst,
  input  dorq_cmd_t                 cmd,
  input  logic                      in_kind,
  input  logic [ID_WIDTH-1:0]       in_job_id,
  input  logic [DEADLINE_WIDTH-1:0] in_deadline,
  output logic                      head_valid,
  output logic [ID_WIDTH-1:0]       head_job,
  output logic [OCC_WIDTH-1:0]      occupancy,
  output logic                      dropped
);

  localparam int LEVELS = $clog2(CAPACITY);

  // Cell contents; only cells below count hold jobs.
  logic [ID_WIDTH-1:0]       job [CAPACITY];
  logic [DEADLINE_WIDTH-1:0] dl [CAPACITY];
  logic [OCC_WIDTH-1:0]      count;

  logic [ID_WIDTH-1:0]       job_next [CAPACITY];
  logic [DEADLINE_WIDTH-1:0] dl_next [CAPACITY];
  logic [OCC_WIDTH-1:0]      count_next;
  logic                      drop_next;

  // Captured operation and per-cell flags.
  logic                      op_kind;
  logic [ID_WIDTH-1:0]       op_id;
  logic [DEADLINE_WIDTH-1:0] op_dl;
  logic [CAPACITY-1:0]       flag;
  logic [CAPACITY-1:0]       flag_in;

  logic [CAPACITY-1:0] pre_lvl [LEVELS+1];
  logic [CAPACITY-1:0] pre;
  logic                full;
  logic                ins_go;
  logic                rem_go;

  // Each held cell compares against the incoming transaction: deadline not
  // later than the new one for an insert, identifier equal for a remove.
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      if (in_kind == KIND_REMOVE) begin
        flag_in[i] = (OCC_WIDTH'(i) < count) && (job[i] == in_job_id);
      end else begin
        flag_in[i] = (OCC_WIDTH'(i) < count) && (dl[i] <= in_deadline);
      end
    end
  end

  // Inclusive prefix OR of the match flags marks the first match and all after it.
  always_comb begin
    pre_lvl[0] = flag;
    for (int l = 0; l < LEVELS; l++) begin
      for (int i = 0; i < CAPACITY; i++) begin
        if (i >= (1 << l)) begin
          pre_lvl[l+1][i] = pre_lvl[l][i] | pre_lvl[l][i-(1<<l)];
        end else begin
          pre_lvl[l+1][i] = pre_lvl[l][i];
        end
      end
    end
    pre = pre_lvl[LEVELS];
  end

  assign full   = (count == OCC_WIDTH'(CAPACITY));
  assign ins_go = (op_kind == KIND_INSERT) && !full;
  assign rem_go = (op_kind == KIND_REMOVE) && pre[CAPACITY-1];

  // Cell update: an insert keeps cells ahead of the slot, writes the slot and
  // shifts the rest back; a remove pulls every cell from the match onward forward.
  always_comb begin
    int  p;
    int  q;
    logic prev_le;
    for (int i = 0; i < CAPACITY; i++) begin
      p = (i == 0) ? 0 : i - 1;
      q = (i == CAPACITY - 1) ? i : i + 1;
      prev_le = (i == 0) ? 1'b1 : flag[p];
      job_next[i] = job[i];
      dl_next[i]  = dl[i];
      if (ins_go && !flag[i]) begin
        if (prev_le) begin
          job_next[i] = op_id;
          dl_next[i]  = op_dl;
        end else begin
          job_next[i] = job[p];
          dl_next[i]  = dl[p];
        end
      end else if (rem_go && pre[i]) begin
        job_next[i] = job[q];
        dl_next[i]  = dl[q];
      end
    end
  end

  // Occupancy and drop flag.
  always_comb begin
    count_next = count;
    drop_next  = 1'b0;
    if (op_kind == KIND_INSERT) begin
      if (full) begin
        drop_next = 1'b1;
      end else begin
        count_next = count + OCC_WIDTH'(1);
      end
    end else if (rem_go) begin
      count_next = count - OCC_WIDTH'(1);
    end
  end

  // Operation capture and result register.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_kind <= in_kind;
      op_id   <= in_job_id;
      op_dl   <= in_deadline;
      flag    <= flag_in;
    end
    if (cmd.apply) begin
      head_valid <= (count_next != '0);
      head_job   <= (count_next != '0) ? job_next[0] : '0;
      occupancy  <= count_next;
      dropped    <= drop_next;
    end
  end

  // Cell storage.
  always_ff @(posedge clk) begin
    if (cmd.apply) begin
      for (int i = 0; i < CAPACITY; i++) begin
        job[i] <= job_next[i];
        dl[i]  <= dl_next[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.apply) begin
      count <= count_next;
    end
  end

  // The queue never holds more jobs than it has cells.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= OCC_WIDTH'(CAPACITY))
    else $error("occupancy exceeds capacity");

endmodule

### hw/rtl/deadline_ordered_ready_queue.sv
// Top level of the deadline-ordered ready queue: controller plus cell datapath.
//
//   channel  role    payload
//   req      sink    kind, job_id, deadline
//   rsp      source  head_valid, head_job, occupancy, dropped
//
// Each transaction is first captured and compared in every cell at once; then,
// once the result register is free, the cells shift and the result register loads.
// A stalled result holds the next operation in its apply step; req is taken
// again once the pending operation has written its result.
// Synchronous reset empties the queue; cell contents are not cleared.
module deadline_ordered_ready_queue
  import dorq_pkg::*;
#(
  parameter int CAPACITY = 16,
  parameter int ID_WIDTH = 10
) (
  input logic        clk,
  input logic        rst,
  dorq_req_if.sink   req,
  dorq_rsp_if.source rsp
);

  localparam int OCC_WIDTH = $clog2(CAPACITY + 1);

  dorq_cmd_t cmd;

  dorq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .cmd       (cmd)
  );

  dorq_dp #(
    .CAPACITY  (CAPACITY),
    .ID_WIDTH  (ID_WIDTH),
    .OCC_WIDTH (OCC_WIDTH)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .in_kind     (req.kind),
    .in_job_id   (req.job_id),
    .in_deadline (req.deadline),
    .head_valid  (rsp.head_valid),
    .head_job    (rsp.head_job),
    .occupancy   (rsp.occupancy),
    .dropped     (rsp.dropped)
  );

endmodule

### tb/tb_deadline_ordered_ready_queue.sv
// Self-checking testbench for the deadline-ordered ready queue with its own sorted-queue predictor.
module tb_deadline_ordered_ready_queue;
  import dorq_pkg::*;

  localparam int CAPACITY    = 16;
  localparam int ID_WIDTH    = 10;
  localparam int OCC_WIDTH   = 5;
  localparam int RANDOM_OPS  = 450;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 20;
  localparam int HOLD_CYCLES = 200;

  typedef struct packed {
    logic                      kind;
    logic [ID_WIDTH-1:0]       job_id;
    logic [DEADLINE_WIDTH-1:0] deadline;
  } queue_op_t;

  typedef struct packed {
    logic                 head_valid;
    logic [ID_WIDTH-1:0]  head_job;
    logic [OCC_WIDTH-1:0] occupancy;
    logic                 dropped;
  } queue_status_t;

  logic clk;
  logic rst;

  dorq_req_if #(.ID_WIDTH(ID_WIDTH)) req_if ();
  dorq_rsp_if #(.ID_WIDTH(ID_WIDTH), .OCC_WIDTH(OCC_WIDTH)) rsp_if ();

  deadline_ordered_ready_queue #(
    .CAPACITY(CAPACITY),
    .ID_WIDTH(ID_WIDTH)
  ) dut (
    .clk(clk),
    .rst(rst),
    .req(req_if),
    .rsp(rsp_if)
  );

  // Shadow copy of the queue contents, kept sorted by deadline.
  logic [ID_WIDTH-1:0]       shadow_job[CAPACITY];
  logic [DEADLINE_WIDTH-1:0] shadow_deadline[CAPACITY];
  int                        shadow_count;

  queue_op_t     pending_ops[$];
  queue_status_t expected_status[$];

  int n_total;
  int n_accepted;
  int n_checked;
  int n_errors;
  int cycle_count;
  int send_gap;
  int recv_wait;
  int hold_left;
  int holds_done;
  logic send_idle;
  logic recv_idle;

  // Clock generation.
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Apply one operation to the shadow queue and return the status it reports.
  function automatic queue_status_t predict_queue_op(queue_op_t op);
    queue_status_t st;
    int pos;
    st = '0;
    pos = 0;
    if (op.kind == KIND_INSERT) begin
      if (shadow_count >= CAPACITY) begin
        st.dropped = 1'b1;
      end else begin
        // Equal deadlines go behind the ones already held.
        while (pos < shadow_count && shadow_deadline[pos] <= op.deadline) pos++;
        for (int k = shadow_count; k > pos; k--) begin
          shadow_job[k]      = shadow_job[k-1];
          shadow_deadline[k] = shadow_deadline[k-1];
        end
        shadow_job[pos]      = op.job_id;
        shadow_deadline[pos] = op.deadline;
        shadow_count++;
      end
    end else begin
      // Only the first match from the head leaves; an absent job changes nothing.
      while (pos < shadow_count && shadow_job[pos] != op.job_id) pos++;
      if (pos < shadow_count) begin
        for (int k = pos; k + 1 < shadow_count; k++) begin
          shadow_job[k]      = shadow_job[k+1];
          shadow_deadline[k] = shadow_deadline[k+1];
        end
        shadow_count--;
      end
    end
    if (shadow_count > 0) begin
      st.head_valid = 1'b1;
      st.head_job   = shadow_job[0];
    end
    st.occupancy = OCC_WIDTH'(shadow_count);
    return st;
  endfunction

  task automatic add_op(logic kind, logic [ID_WIDTH-1:0] id, logic [DEADLINE_WIDTH-1:0] dl);
    queue_op_t op;
    op.kind     = kind;
    op.job_id   = id;
    op.deadline = dl;
    pending_ops.push_back(op);
  endtask

  task automatic report_mismatch(string field, int unsigned exp_val, int unsigned act_val);
    n_errors++;
    if (n_errors <= 10)
      $display("mismatch on %s at result %0d: expected %0d, got %0d",
               field, n_checked, exp_val, act_val);
  endtask

  // Random identifier: mostly a small pool so removes find their job, sometimes any value.
  function automatic logic [ID_WIDTH-1:0] pick_job_id();
    if ($urandom_range(0, 9) < 7) return ID_WIDTH'($urandom_range(0, 15));
    return ID_WIDTH'($urandom_range(0, (1 << ID_WIDTH) - 1));
  endfunction

  // Random deadline: small values for ties, the extremes, or any 32-bit value.
  function automatic logic [DEADLINE_WIDTH-1:0] pick_deadline();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel < 4) return DEADLINE_WIDTH'($urandom_range(0, 7));
    if (sel == 4) return ($urandom_range(0, 1) != 0) ? '1 : '0;
    return $urandom;
  endfunction

  // Stimulus, reset and end of run.
  initial begin
    int insert_pct;
    req_if.valid    = 1'b0;
    req_if.kind     = KIND_INSERT;
    req_if.job_id   = '0;
    req_if.deadline = '0;
    rsp_if.ready    = 1'b0;
    rst             = 1'b1;
    shadow_count    = 0;

    // Directed part: empty remove, extremes, ties, duplicate ids, absent remove.
    add_op(KIND_REMOVE, 10'd3, 32'd0);
    add_op(KIND_INSERT, 10'd1023, 32'hFFFF_FFFF);
    add_op(KIND_INSERT, 10'd0, 32'd0);
    add_op(KIND_INSERT, 10'd512, 32'd0);
    add_op(KIND_INSERT, 10'd7, 32'h8000_0000);
    add_op(KIND_INSERT, 10'd7, 32'd1);
    add_op(KIND_REMOVE, 10'd7, 32'hFFFF_FFFF);
    add_op(KIND_REMOVE, 10'd999, 32'd0);
    add_op(KIND_REMOVE, 10'd0, 32'd0);
    // Three jobs remain; fill the queue, then insert twice into a full queue.
    for (int i = 0; i < CAPACITY - 3; i++)
      add_op(KIND_INSERT, ID_WIDTH'($urandom_range(0, 1023)), $urandom);
    add_op(KIND_INSERT, 10'd1, 32'd0);
    add_op(KIND_INSERT, 10'd1022, 32'hFFFF_FFFF);

    // Random part in stretches that lean toward filling or draining the queue.
    insert_pct = 50;
    for (int i = 0; i < RANDOM_OPS; i++) begin
      if (i % 30 == 0) begin
        case ($urandom_range(0, 3))
          0: insert_pct = 20;
          1: insert_pct = 50;
          2: insert_pct = 80;
          default: insert_pct = 95;
        endcase
      end
      if ($urandom_range(0, 99) < insert_pct)
        add_op(KIND_INSERT, pick_job_id(), pick_deadline());
      else
        add_op(KIND_REMOVE, pick_job_id(), $urandom);
    end
    n_total = pending_ops.size();

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    while (n_accepted < n_total || expected_status.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (expected_status.size() != 0) n_errors++;
    if (n_errors == 0)
      $display("PASS deadline_ordered_ready_queue");
    else
      $display("FAIL deadline_ordered_ready_queue");
    $finish;
  end

  // Request driver: offers queued items with random gaps and predicts each accepted one.
  always @(posedge clk) begin : drive_requests
    queue_op_t op;
    if (rst) begin
      req_if.valid <= 1'b0;
      send_gap     <= 0;
      send_idle    <= 1'b0;
      n_accepted   <= 0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        op.kind     = req_if.kind;
        op.job_id   = req_if.job_id;
        op.deadline = req_if.deadline;
        expected_status.push_back(predict_queue_op(op));
        n_accepted <= n_accepted + 1;
        if (n_accepted % 32 == 31) send_idle <= 1'($urandom_range(0, 1));
      end
      if (!req_if.valid || req_if.ready) begin
        if (send_gap != 0) begin
          send_gap     <= send_gap - 1;
          req_if.valid <= 1'b0;
        end else if (pending_ops.size() != 0) begin
          op = pending_ops.pop_front();
          req_if.valid    <= 1'b1;
          req_if.kind     <= op.kind;
          req_if.job_id   <= op.job_id;
          req_if.deadline <= op.deadline;
          send_gap        <= send_idle ? $urandom_range(0, 15) : 0;
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-offs so that the queue backs up and stalls the request side.
  always @(posedge clk) begin
    if (rst) begin
      hold_left  <= 0;
      holds_done <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if ((holds_done == 0 && n_accepted >= 60) ||
                 (holds_done == 1 && n_accepted >= 250)) begin
      hold_left  <= HOLD_CYCLES;
      holds_done <= holds_done + 1;
    end
  end

  // Response monitor: checks each transaction against the oldest prediction.
  always @(posedge clk) begin : check_responses
    queue_status_t exp_st;
    int next_wait;
    if (rst) begin
      rsp_if.ready <= 1'b0;
      recv_wait    <= 0;
      recv_idle    <= 1'b0;
      n_checked    <= 0;
    end else begin
      next_wait = (recv_wait > 0) ? recv_wait - 1 : 0;
      if (rsp_if.valid && rsp_if.ready) begin
        if (expected_status.size() == 0) begin
          n_errors++;
          if (n_errors <= 10) $display("unexpected result with nothing outstanding");
        end else begin
          exp_st = expected_status.pop_front();
          if (rsp_if.head_valid !== exp_st.head_valid)
            report_mismatch("head_valid", 32'(exp_st.head_valid), 32'(rsp_if.head_valid));
          if (rsp_if.head_job !== exp_st.head_job)
            report_mismatch("head_job", 32'(exp_st.head_job), 32'(rsp_if.head_job));
          if (rsp_if.occupancy !== exp_st.occupancy)
            report_mismatch("occupancy", 32'(exp_st.occupancy), 32'(rsp_if.occupancy));
          if (rsp_if.dropped !== exp_st.dropped)
            report_mismatch("dropped", 32'(exp_st.dropped), 32'(rsp_if.dropped));
        end
        n_checked <= n_checked + 1;
        if (n_checked % 32 == 31) recv_idle <= 1'($urandom_range(0, 1));
        next_wait = recv_idle ? $urandom_range(0, 15) : 0;
      end
      recv_wait    <= next_wait;
      rsp_if.ready <= (next_wait == 0) && (hold_left == 0);
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL deadline_ordered_ready_queue");
      $finish;
    end
  end

  initial cycle_count = 0;
  initial n_errors = 0;

endmodule
